// ===== rtl/keypad_scan_debounce_queue_macros.svh =====
// Assertion macros for the keypad scanner RTL.
// Included by the scanner top module, which checks its own control logic.
`ifndef KEYPAD_SCAN_DEBOUNCE_QUEUE_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KSDQ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define KSDQ_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ksdq_pkg.sv =====
// Shared types, constants and the key code table of the keypad scanner.
// No dependencies; used by every module of the block.
package ksdq_pkg;

   localparam int CFG_W   = 4;
   localparam int CODE_W  = 7;
   localparam int LEVEL_W = 3;
   localparam int DRIVE_W = 2;
   localparam int CNT_W   = 4;

   localparam int TABLE_ROWS = 4;
   localparam int TABLE_COLS = 3;

   // Debounce count after reset, also the counter value of untouched keys
   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 4'd5;

   // Item kinds on the request channel
   localparam logic MODE_SCAN = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef logic [CODE_W-1:0] code_type;

   // Queue requests from the scan pipeline
   typedef struct packed {
      logic     push;
      code_type push_code;
      logic     pop;
   } fifo_ctl_type;

   // Queue status back to the scan pipeline
   typedef struct packed {
      logic empty;
      logic full;
      logic empty_next;
   } fifo_sts_type;

   localparam code_type CODE_TABLE [TABLE_ROWS][TABLE_COLS] = '{
      '{7'h31, 7'h32, 7'h33},   // 1 2 3
      '{7'h34, 7'h35, 7'h36},   // 4 5 6
      '{7'h37, 7'h38, 7'h39},   // 7 8 9
      '{7'h2A, 7'h30, 7'h23}    // * 0 #
   };

   // ASCII code of a key; keys outside the 4 x 3 pad give zero
   function automatic code_type code_of(input int unsigned row, input int unsigned col);
      code_type result;
      result = '0;
      if (row < TABLE_ROWS && col < TABLE_COLS) begin
         result = CODE_TABLE[row[1:0]][col[1:0]];
      end
      return result;
   endfunction

endpackage

// ===== rtl/ksdq_row_mem.sv =====
// Per-row debounce state memory: previous levels, confirmed levels and counters.
// Synchronous read with write forwarding; uses ksdq_pkg.
module ksdq_row_mem #(
   parameter int ROWS    = 4,
   parameter int COLUMNS = 3,
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1,
   localparam int REC_W  = COLUMNS * (ksdq_pkg::CNT_W + 2)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ROW_AW-1:0] rd_addr,
   output logic [REC_W-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ROW_AW-1:0] wr_addr,
   input  logic [REC_W-1:0]  wr_data
);
   import ksdq_pkg::*;

   // Record layout: {counters, confirmed levels, previous levels}
   localparam logic [REC_W-1:0] RESET_REC = {{COLUMNS{DEBOUNCE_RESET}}, {(2 * COLUMNS){1'b0}}};

   logic [REC_W-1:0]  row_mem_ff [ROWS];
   logic [ROWS-1:0]   row_vld_ff;
   logic [REC_W-1:0]  rd_raw_ff;
   logic              rd_vld_ff;
   logic [ROW_AW-1:0] rd_addr_ff;
   logic [REC_W-1:0]  fwd_data_ff;
   logic [ROW_AW-1:0] fwd_addr_ff;
   logic              fwd_vld_ff;
   logic              fwd_hit;

   // Write port and synchronous read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff  <= row_mem_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr_en) begin
         fwd_data_ff <= wr_data;
         fwd_addr_ff <= wr_addr;
      end
   end

   // Row valid bits stand in for a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[wr_addr] <= 1'b1;
            fwd_vld_ff          <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= row_vld_ff[rd_addr];
         end
      end
   end

   // Forward the latest write: it may land on the edge of the read
   assign fwd_hit = fwd_vld_ff && (fwd_addr_ff == rd_addr_ff);

   always_comb begin
      if (fwd_hit) begin
         rd_data = fwd_data_ff;
      end else if (rd_vld_ff) begin
         rd_data = rd_raw_ff;
      end else begin
         rd_data = RESET_REC;
      end
   end

endmodule

// ===== rtl/ksdq_key_fifo.sv =====
// Key code queue: code memory, read and write pointers and fill count.
// Pushes to a full queue are dropped; uses ksdq_pkg.
module ksdq_key_fifo #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ksdq_pkg::fifo_ctl_type ctl,
   output ksdq_pkg::fifo_sts_type sts,
   output ksdq_pkg::code_type     rd_code
);
   import ksdq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W_Q-1:0] CNT_FULL = CNT_W_Q'(QUEUE_DEPTH);

   code_type            key_mem_ff [QUEUE_DEPTH];
   code_type            rd_code_ff;
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CNT_W_Q-1:0]  count_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W_Q-1:0]  count_in;
   logic                do_push;
   logic                do_pop;

   assign sts.full  = (count_ff == CNT_FULL);
   assign sts.empty = (count_ff == '0);
   assign do_push   = ctl.push && !sts.full;
   assign do_pop    = ctl.pop && !sts.empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   assign sts.empty_next = (count_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Code memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (do_push) begin
         key_mem_ff[wr_ptr_ff] <= ctl.push_code;
      end
      if (do_pop) begin
         rd_code_ff <= key_mem_ff[rd_ptr_ff];
      end
   end

   assign rd_code = rd_code_ff;

endmodule

// ===== rtl/keypad_scan_debounce_queue.sv =====
// Keypad scanner with per-key debounce and a key code queue.
// A request is registered in the compute stage, then in the output register.
// Throughput: one item per cycle while replies are taken; a scan tick that confirms
// several presses in its row holds its stage until all are pushed (one write port).
// Reset: synchronous; row state reads as reset through per-row valid bits
// (no clearing pass), queue empties, debounce count returns to 5.
module keypad_scan_debounce_queue #(
   parameter int ROWS        = 4,
   parameter int COLUMNS     = 3,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [ksdq_pkg::CFG_W-1:0]   csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic [ksdq_pkg::LEVEL_W-1:0] req_column_levels,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_key_valid,
   output ksdq_pkg::code_type           rsp_key_code,
   output logic [ksdq_pkg::DRIVE_W-1:0] rsp_drive_row,
   output logic                         rsp_queue_empty
);
   import ksdq_pkg::*;

   `include "keypad_scan_debounce_queue_macros.svh"

   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int REC_W  = COLUMNS * (CNT_W + 2);
   localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);

   logic [CFG_W-1:0]   debounce_ff;
   logic [ROW_AW-1:0]  row_ff;
   logic [ROW_AW-1:0]  row_in;

   // Compute stage
   logic               s1_valid_ff;
   logic               s1_mode_ff;
   logic [LEVEL_W-1:0] s1_levels_ff;
   logic [ROW_AW-1:0]  s1_row_ff;
   logic [DRIVE_W-1:0] s1_drive_ff;
   logic [COLUMNS-1:0] s1_done_ff;
   logic [COLUMNS-1:0] s1_done_in;

   // Output register
   logic               rsp_valid_ff;
   logic               rsp_key_valid_ff;
   logic [DRIVE_W-1:0] rsp_drive_row_ff;
   logic               rsp_queue_empty_ff;

   logic               req_xfer;
   logic               s1_adv;
   logic               out_free;
   logic [REC_W-1:0]   rec_rd;
   logic [REC_W-1:0]   rec_wr;
   logic [COLUMNS-1:0] press;
   logic [COLUMNS-1:0] pending;
   logic [COLUMNS-1:0] first;
   logic [COLUMNS-1:0] rest;
   code_type           first_code;
   fifo_ctl_type       fifo_ctl;
   fifo_sts_type       fifo_sts;
   code_type           fifo_rd_code;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         debounce_ff <= csr_wdata;
      end
   end

   // Handshake: hold the compute stage until its pushes are done and output is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && (rest == '0) && out_free;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_xfer  = req_valid && req_ready;

   // Advance the scanned row on each scan transfer
   always_comb begin
      row_in = row_ff;
      if (req_xfer && req_mode == MODE_SCAN) begin
         row_in = (row_ff == ROW_LAST) ? '0 : row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s1_done_ff  <= '0;
      end else begin
         row_ff     <= row_in;
         s1_done_ff <= s1_done_in;
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_mode_ff   <= req_mode;
         s1_levels_ff <= req_column_levels;
         s1_row_ff    <= row_ff;
         s1_drive_ff  <= DRIVE_W'(row_in);
      end
   end

   // Row state memory
   ksdq_row_mem #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer && req_mode == MODE_SCAN),
      .rd_addr (row_ff),
      .rd_data (rec_rd),
      .wr_en   (s1_adv && s1_mode_ff == MODE_SCAN),
      .wr_addr (s1_row_ff),
      .wr_data (rec_wr)
   );

   // Debounce update, one slice per column
   for (genvar c = 0; c < COLUMNS; c++) begin : g_col
      logic             lvl;
      logic             prev;
      logic             conf;
      logic [CNT_W-1:0] cnt;
      logic             prev_n;
      logic             conf_n;
      logic [CNT_W-1:0] cnt_n;
      logic             hit;

      if (c < LEVEL_W) begin : g_lvl
         assign lvl = s1_levels_ff[c];
      end else begin : g_zero
         assign lvl = 1'b0;
      end

      assign prev = rec_rd[c];
      assign conf = rec_rd[COLUMNS + c];
      assign cnt  = rec_rd[2 * COLUMNS + c * CNT_W +: CNT_W];

      always_comb begin
         prev_n = prev;
         conf_n = conf;
         cnt_n  = cnt;
         hit    = 1'b0;
         if (lvl == prev) begin
            if (cnt != '0) begin
               cnt_n = cnt - 1'b1;
               if (cnt_n == '0 && lvl != conf) begin
                  conf_n = lvl;
                  hit    = (lvl == 1'b0);
               end
            end
         end else begin
            prev_n = lvl;
            cnt_n  = debounce_ff;
         end
      end

      assign rec_wr[c]                                = prev_n;
      assign rec_wr[COLUMNS + c]                      = conf_n;
      assign rec_wr[2 * COLUMNS + c * CNT_W +: CNT_W] = cnt_n;
      assign press[c] = hit && s1_valid_ff && (s1_mode_ff == MODE_SCAN);
   end

   // Push confirmed presses one per cycle, lowest column first, last with stage advance
   assign pending = press & ~s1_done_ff;
   assign first   = pending & (~pending + 1'b1);
   assign rest    = pending & ~first;

   always_comb begin
      first_code = '0;
      for (int c = 0; c < COLUMNS; c++) begin
         if (first[c]) begin
            first_code = code_of(32'(s1_row_ff), c);
         end
      end
   end

   assign fifo_ctl.push      = (pending != '0) && ((rest != '0) || s1_adv);
   assign fifo_ctl.push_code = first_code;
   assign fifo_ctl.pop       = s1_adv && (s1_mode_ff == MODE_POP) && !fifo_sts.empty;

   always_comb begin
      s1_done_in = s1_done_ff;
      if (s1_adv) begin
         s1_done_in = '0;
      end else if (fifo_ctl.push) begin
         s1_done_in = s1_done_ff | first;
      end
   end

   ksdq_key_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_key_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fifo_ctl),
      .sts     (fifo_sts),
      .rd_code (fifo_rd_code)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_key_valid_ff   <= fifo_ctl.pop;
         rsp_drive_row_ff   <= s1_drive_ff;
         rsp_queue_empty_ff <= fifo_sts.empty_next;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_key_valid   = rsp_key_valid_ff;
   assign rsp_key_code    = rsp_key_valid_ff ? fifo_rd_code : '0;
   assign rsp_drive_row   = rsp_drive_row_ff;
   assign rsp_queue_empty = rsp_queue_empty_ff;

   `KSDQ_ASSERT_IMP(a_push_pop_excl, fifo_ctl.push, !fifo_ctl.pop, "push and pop in one cycle")
   `KSDQ_ASSERT_IMP(a_pop_nonempty, fifo_ctl.pop, !fifo_sts.empty, "pop issued on empty queue")
   `KSDQ_ASSERT_NXT(a_pending_holds, s1_valid_ff && (rest != '0), s1_valid_ff, "stage left with pushes due")
   `KSDQ_ASSERT_NXT(a_done_clears, s1_adv, s1_done_ff == '0, "push marks kept after advance")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the keypad scanner: scan ticks and pops against a key-queue scoreboard.
// Depends on ksdq_pkg and keypad_scan_debounce_queue from the RTL folder.
module testbench;

   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned LONG_HOLD     = 300;
   localparam logic [3:0]  DEBOUNCE_INIT = 4'd5;
   localparam string       KEY_CHARS     = "123456789*0#";

   typedef struct packed {
      logic                 key_valid;
      ksdq_pkg::code_type   key_code;
      logic [1:0]           drive_row;
      logic                 queue_empty;
   } key_reply_type;

   // Shadow of the scanner: row state, debounce counters, key queue, replies due
   class key_queue_board;
      logic [3:0]         debounce_setting;
      logic [1:0]         row_now;
      logic [2:0]         seen_levels [4];
      logic [2:0]         stable_levels [4];
      logic [3:0]         settle_count [12];
      ksdq_pkg::code_type key_store [16];
      logic [3:0]         wr_ptr;
      logic [3:0]         rd_ptr;
      int unsigned        stored;
      key_reply_type      key_replies [$];
      int unsigned        mismatches;

      function new();
         debounce_setting = DEBOUNCE_INIT;
         row_now = '0;
         foreach (seen_levels[r]) begin
            seen_levels[r] = '0;
            stable_levels[r] = '0;
         end
         foreach (settle_count[k]) settle_count[k] = DEBOUNCE_INIT;
         foreach (key_store[i]) key_store[i] = '0;
         wr_ptr = '0;
         rd_ptr = '0;
         stored = 0;
         mismatches = 0;
      endfunction

      function void set_debounce(logic [3:0] value);
         debounce_setting = value;
      endfunction

      function int unsigned outstanding();
         return key_replies.size();
      endfunction

      // Queue a confirmed press; drop it when the queue is full
      function void push_key(ksdq_pkg::code_type code);
         if (stored < 16) begin
            key_store[wr_ptr] = code;
            wr_ptr = wr_ptr + 4'd1;
            stored++;
         end
      endfunction

      // Debounce each column of the current row, then advance the row
      function void scan_row(logic [2:0] levels);
         int unsigned r;
         int unsigned k;
         logic lvl;
         r = row_now;
         for (int unsigned c = 0; c < 3; c++) begin
            k = r * 3 + c;
            lvl = levels[c];
            if (lvl == seen_levels[r][c]) begin
               if (settle_count[k] != 0) begin
                  settle_count[k] = settle_count[k] - 4'd1;
                  if (settle_count[k] == 0 && lvl != stable_levels[r][c]) begin
                     stable_levels[r][c] = lvl;
                     if (!lvl) push_key(7'(KEY_CHARS[k]));
                  end
               end
            end else begin
               seen_levels[r][c] = lvl;
               settle_count[k] = debounce_setting;
            end
         end
         row_now = row_now + 2'd1;
      endfunction

      // Work out the reply to one accepted request
      function void apply_request(logic mode, logic [2:0] levels);
         key_reply_type reply;
         reply.key_valid = 1'b0;
         reply.key_code = '0;
         if (mode == ksdq_pkg::MODE_SCAN) begin
            scan_row(levels);
         end else if (stored != 0) begin
            reply.key_valid = 1'b1;
            reply.key_code = key_store[rd_ptr];
            rd_ptr = rd_ptr + 4'd1;
            stored--;
         end
         reply.drive_row = row_now;
         reply.queue_empty = (stored == 0);
         key_replies.push_back(reply);
      endfunction

      // Compare a reply transfer with the oldest one due
      function void check_reply(key_reply_type got);
         key_reply_type want;
         if (key_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected reply: valid=%0d code=%h row=%0d empty=%0d",
                        got.key_valid, got.key_code, got.drive_row, got.queue_empty);
         end else begin
            want = key_replies.pop_front();
            if (got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
                got.drive_row !== want.drive_row || got.queue_empty !== want.queue_empty) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("reply mismatch: want valid=%0d code=%h row=%0d empty=%0d, got valid=%0d code=%h row=%0d empty=%0d",
                           want.key_valid, want.key_code, want.drive_row, want.queue_empty,
                           got.key_valid, got.key_code, got.drive_row, got.queue_empty);
            end
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_we = 1'b0;
   logic [ksdq_pkg::CFG_W-1:0]   csr_wdata = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_mode = 1'b0;
   logic [ksdq_pkg::LEVEL_W-1:0] req_column_levels = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_key_valid;
   ksdq_pkg::code_type           rsp_key_code;
   logic [ksdq_pkg::DRIVE_W-1:0] rsp_drive_row;
   logic                         rsp_queue_empty;

   key_queue_board board;
   int unsigned    cycle_count = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    ready_stall_pct = 0;
   int unsigned    hold_requests = 0;
   int unsigned    holds_served = 0;
   int unsigned    hold_left = 0;
   logic [2:0]     held_levels [4] = '{default: 3'b000};

   keypad_scan_debounce_queue DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_column_levels (req_column_levels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_key_valid     (rsp_key_valid),
      .rsp_key_code      (rsp_key_code),
      .rsp_drive_row     (rsp_drive_row),
      .rsp_queue_empty   (rsp_queue_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Drive reply ready: long holds on request, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= ready_stall_pct);
      end
   end

   // Check every reply transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_reply('{rsp_key_valid, rsp_key_code, rsp_drive_row, rsp_queue_empty});
   end

   // Offer one request and hold it until the transfer; valid stays high afterwards
   task automatic send_item(input logic mode, input logic [2:0] levels);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_column_levels <= levels;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.apply_request(mode, levels);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   task automatic write_debounce(input logic [3:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_debounce(value);
   endtask

   // Scan every row with the same levels
   task automatic sweep(input logic [2:0] levels, input int unsigned sweeps);
      repeat (sweeps * 4) send_item(ksdq_pkg::MODE_SCAN, levels);
   endtask

   // Mostly held row patterns so keys settle; some bounce and pops mixed in
   task automatic send_random(input int unsigned pop_pct);
      logic [2:0]  levels;
      logic        mode;
      int unsigned r;
      levels = 3'($urandom_range(7));
      r = board.row_now;
      if ($urandom_range(99) < pop_pct) begin
         mode = ksdq_pkg::MODE_POP;
      end else begin
         mode = ksdq_pkg::MODE_SCAN;
         if ($urandom_range(99) >= 8) begin
            if ($urandom_range(board.debounce_setting + 2) == 0) held_levels[r] = levels;
            levels = held_levels[r];
         end
      end
      send_item(mode, levels);
   endtask

   // Settle, reconfigure, then run random traffic with one idling profile
   task automatic run_phase(input logic [3:0] debounce, input int unsigned n_items,
                            input int unsigned pop_pct, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned hold_at,
                            input int unsigned pause_at);
      stop_sending();
      wait_drained();
      repeat (4) @(posedge clock);
      write_debounce(debounce);
      send_idle_pct = idle_pct;
      ready_stall_pct = stall_pct;
      for (int unsigned i = 0; i < n_items; i++) begin
         if (i == hold_at) hold_requests++;
         if (i == pause_at) begin
            stop_sending();
            wait_drained();
         end
         send_random(pop_pct);
      end
   endtask

   initial begin
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Pop with nothing queued, then load the middle column's counters with the reset debounce count
      send_item(ksdq_pkg::MODE_POP, 3'b111);
      sweep(3'b010, 1);
      stop_sending();
      wait_drained();
      repeat (4) @(posedge clock);

      // Shortest debounce: release and press the whole pad twice to overflow the queue
      write_debounce(4'd1);
      sweep(3'b111, 2);
      sweep(3'b000, 2);
      sweep(3'b111, 2);
      sweep(3'b000, 2);
      repeat (4) send_item(ksdq_pkg::MODE_POP, 3'b101);

      run_phase(4'd15, 60, 15, 0, 0, 1000, 1000);
      run_phase(4'd0, 50, 20, 54, 0, 1000, 1000);
      run_phase(4'd3, 90, 5, 0, 54, 30, 1000);
      run_phase(4'd1, 80, 35, 15, 15, 1000, 40);
      run_phase(4'd5, 70, 20, 0, 0, 1000, 1000);
      run_phase(4'd2, 60, 50, 54, 0, 1000, 1000);

      stop_sending();
      wait_drained();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
